### hw/rtl/cti_pkg.sv
// Shared constants and types for the calibration table interpolator.
package cti_pkg;
  localparam int TableDepth = 64;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = $clog2(TableDepth + 1);
  localparam int FreqW = 26;
  localparam int GainW = 18;
  localparam int PhaseW = 20;
  localparam int FracW = 17;
  localparam int EntryW = FreqW + GainW + PhaseW;
  localparam logic [GainW-1:0] UnityGain = GainW'(65536);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [FreqW-1:0]  freq;
    logic [GainW-1:0]  gain;
    logic signed [PhaseW-1:0] phase;
  } entry_t;
endpackage

### hw/rtl/cti_ram.sv
// Generic single-port synchronous RAM with registered read.
module cti_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/cti_divider.sv
// Restoring divider for the 17-bit interpolation fraction.
module cti_divider
  import cti_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [FreqW-1:0] num,
  input  logic [FreqW-1:0] den,
  output logic             done,
  output logic [FracW-1:0] quot
);
  localparam int Steps = FreqW + 16;
  localparam int StepW = $clog2(Steps + 1);

  logic [Steps-1:0] dividend;
  logic [FreqW:0]   rem;
  logic [FreqW-1:0] dsr;
  logic [StepW-1:0] steps_left;
  logic             busy;
  logic [FreqW:0]   shifted;
  logic [FreqW:0]   diff;

  assign shifted = {rem[FreqW-1:0], dividend[Steps-1]};
  assign diff = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dividend <= {num, 16'd0};
        dsr <= den;
        rem <= '0;
        steps_left <= StepW'(Steps);
      end else if (busy) begin
        dividend <= {dividend[Steps-2:0], ~diff[FreqW]};
        rem <= diff[FreqW] ? shifted : diff;
        steps_left <= steps_left - 1'b1;
        if (steps_left == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = dividend[FracW-1:0];
endmodule

### hw/rtl/calibration_table_interpolator.sv
// Top level of the calibration table interpolator.
// One transaction at a time. Clear, append, unused codes and lookups on an empty table give a
// result the cycle after acceptance. A lookup reads the first and last points (and stops there
// when it clamps to an end), then scans the table one entry per cycle through a single-port
// RAM, then runs a restoring division and a multiply and sum.
// The result waits in an output register; the next input is taken once it has gone.
module calibration_table_interpolator
  import cti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic [FreqW-1:0]         point_freq,
  input  logic [GainW-1:0]         point_gain,
  input  logic signed [PhaseW-1:0] point_phase,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [GainW-1:0]         interp_gain,
  output logic signed [PhaseW-1:0] interp_phase,
  output logic                     accepted,
  output logic [6:0]               point_count,
  output logic                     table_ready
);
  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_DIV, S_MUL, S_SUM, S_OUT
  } state_t;

  state_t state;
  logic [CountW-1:0] count;
  logic [AddrW-1:0]  addr;
  logic [CountW-1:0] idx;
  logic              we;
  entry_t            wdata, rdata, prev;
  logic [FreqW-1:0]  query;
  logic              div_start, div_done;
  logic [FracW-1:0]  frac;
  logic signed [GainW:0]     dg;
  logic signed [PhaseW:0]    dp;
  logic signed [GainW+FracW+1:0]  pg;
  logic signed [PhaseW+FracW+1:0] pp;
  logic signed [GainW+FracW+1:0]  pg_sum;
  logic signed [PhaseW+FracW+1:0] pp_sum;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign wdata = '{freq: point_freq, gain: point_gain, phase: point_phase};
  assign we = in_valid && in_ready && opcode == OP_APPEND && count < CountW'(TableDepth);

  always_comb begin
    addr = idx[AddrW-1:0];
    if (state == S_IDLE) begin
      addr = we ? count[AddrW-1:0] : '0;
    end
  end

  cti_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign div_start = (state == S_SCAN) && query <= rdata.freq && idx != '0;

  cti_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(query - prev.freq), .den(rdata.freq - prev.freq),
    .done(div_done), .quot(frac)
  );

  assign pg_sum = (pg >>> 16) + $signed({2'b0, prev.gain});
  assign pp_sum = (pp >>> 16) + (PhaseW+FracW+2)'(prev.phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            query <= point_freq;
            interp_gain <= '0;
            interp_phase <= '0;
            accepted <= 1'b1;
            case (opcode)
              OP_CLEAR: begin
                count <= '0;
                point_count <= '0;
                table_ready <= 1'b0;
                out_valid <= 1'b1;
              end
              OP_APPEND: begin
                if (we) begin
                  count <= count + 1'b1;
                  point_count <= 7'(count + 1'b1);
                  table_ready <= (count + 1'b1) >= CountW'(2);
                end else begin
                  accepted <= 1'b0;
                  point_count <= 7'(count);
                  table_ready <= count >= CountW'(2);
                end
                out_valid <= 1'b1;
              end
              OP_LOOKUP: begin
                point_count <= 7'(count);
                table_ready <= count >= CountW'(2);
                if (count == '0) begin
                  interp_gain <= UnityGain;
                  out_valid <= 1'b1;
                end else begin
                  idx <= count - 1'b1;
                  state <= S_FIRST;
                end
              end
              default: begin
                point_count <= 7'(count);
                table_ready <= count >= CountW'(2);
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_FIRST: begin
          if (query <= rdata.freq) begin
            interp_gain <= rdata.gain;
            interp_phase <= rdata.phase;
            state <= S_OUT;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (query >= rdata.freq) begin
            interp_gain <= rdata.gain;
            interp_phase <= rdata.phase;
            state <= S_OUT;
          end else begin
            idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (div_start) begin
            dg <= $signed({1'b0, rdata.gain}) - $signed({1'b0, prev.gain});
            dp <= (PhaseW+1)'(rdata.phase) - (PhaseW+1)'(prev.phase);
            state <= S_DIV;
          end else begin
            prev <= rdata;
            idx <= idx + 1'b1;
          end
        end
        S_DIV: if (div_done) state <= S_MUL;
        S_MUL: begin
          pg <= $signed({1'b0, frac}) * dg;
          pp <= $signed({1'b0, frac}) * dp;
          state <= S_SUM;
        end
        S_SUM: begin
          interp_gain <= pg_sum[GainW-1:0];
          interp_phase <= pp_sum[PhaseW-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ast_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(TableDepth)) else $error("count beyond depth");
  ast_write_idle: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_IDLE) else $error("write outside idle");
  ast_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("accept while busy");
endmodule
